@@ hw/rtl/xoshiro256ss_generator_assert.svh @@
// Assertion macros for the xoshiro256** generator checker
`ifndef XOSHIRO256SS_GENERATOR_ASSERT_SVH
`define XOSHIRO256SS_GENERATOR_ASSERT_SVH

`define XS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define XS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/xs_pkg.sv @@
// Package: types, constants and helpers for the xoshiro256** generator
`timescale 1ns / 1ps
`default_nettype none
package xs_pkg;
	localparam int WordW = 64;
	localparam int ActW = 3;
	localparam int CntW = 8;

	localparam logic [ActW-1:0] ACT_NEXT  = 3'd0;
	localparam logic [ActW-1:0] ACT_B32   = 3'd1;
	localparam logic [ActW-1:0] ACT_B64   = 3'd2;
	localparam logic [ActW-1:0] ACT_JUMP  = 3'd3;
	localparam logic [ActW-1:0] ACT_LJUMP = 3'd4;

	localparam logic [WordW-1:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [WordW-1:0] MIX1   = 64'hbf58476d1ce4e5b9;
	localparam logic [WordW-1:0] MIX2   = 64'h94d049bb133111eb;
	localparam logic [4*WordW-1:0] JUMP_POLY = {64'h39abdc4529b1661c,
		64'ha9582618e03fc9aa, 64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
	localparam logic [4*WordW-1:0] LJUMP_POLY = {64'h39109bb02acbe635,
		64'h77710069854ee241, 64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE, OP_SEED, OP_MIXA, OP_MIXB, OP_MIXSUM, OP_MIXC, OP_LOAD,
		OP_DRAW, OP_MUL, OP_ADD, OP_CMP, OP_DIVINIT, OP_DIVSTEP,
		OP_LEAPCLR, OP_LEAP, OP_LEAPEND, OP_ZERO
	} op_t;

	typedef struct packed {
		op_t op;
		logic wide;
	} cmd_t;

	typedef struct packed {
		logic reject;
		logic need_thr;
		logic div_done;
		logic leap_done;
	} stat_t;

	function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
		input int k);
		rotl = (v << k) | (v >> (WordW - k));
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/xs_datapath.sv @@
// Datapath: state words, seed expansion, multiplier, divider and leap accumulator
`timescale 1ns / 1ps
`default_nettype none
module xs_datapath (
	input  wire logic                    clk,
	input  wire xs_pkg::cmd_t            cmd,
	input  wire logic [xs_pkg::WordW-1:0] seed_val,
	input  wire logic [xs_pkg::ActW-1:0] action,
	input  wire logic [xs_pkg::WordW-1:0] limit,
	output xs_pkg::stat_t                stat,
	output logic [xs_pkg::WordW-1:0]     result
);
	import xs_pkg::*;

	logic [WordW-1:0] w_q [4];
	logic [WordW-1:0] acc_q [4];
	logic [WordW-1:0] sacc_q, z_q, s_q, r_q, thr_q, lo_q, rem_q, num_q;
	logic [WordW-1:0] m0_q;
	logic [31:0] m1_q, m2_q;
	logic [WordW-1:0] p_q [4];
	logic [1:0] widx_q;
	logic [CntW-1:0] bit_q;
	logic [6:0] dcnt_q;
	logic [4*WordW-1:0] poly;
	logic [WordW-1:0] nw [4];
	logic [WordW-1:0] out_raw, t17, w1x5, rnd;
	logic [WordW-1:0] mx, mc;
	logic [WordW:0] rem_sh, rem_sub;
	logic [127:0] prod;
	logic [WordW-1:0] lo_x;

	assign t17 = w_q[1] << 17;
	assign w1x5 = w_q[1] * 64'd5;
	assign rnd = out_raw * 64'd9;
	always_comb begin
		nw[2] = w_q[2] ^ w_q[0];
		nw[3] = w_q[3] ^ w_q[1];
		nw[1] = w_q[1] ^ nw[2];
		nw[0] = w_q[0] ^ nw[3];
		nw[2] = nw[2] ^ t17;
		nw[3] = rotl(nw[3], 45);
	end
	always_comb begin
		if (cmd.op == OP_MIXA) begin
			mx = sacc_q ^ (sacc_q >> 30);
			mc = MIX1;
		end else begin
			mx = z_q ^ (z_q >> 27);
			mc = MIX2;
		end
	end
	assign poly = (action == ACT_LJUMP) ? LJUMP_POLY : JUMP_POLY;
	assign rem_sh = {rem_q, num_q[WordW-1]};
	assign rem_sub = rem_sh - {1'b0, s_q};
	assign prod = {p_q[3], 64'd0} + {32'd0, p_q[2], 32'd0}
		+ {32'd0, p_q[1], 32'd0} + {64'd0, p_q[0]};
	assign lo_x = cmd.wide ? lo_q : {32'd0, lo_q[31:0]};

	always_comb begin
		stat.reject = (lo_x < thr_q);
		stat.need_thr = (s_q != '0) && (lo_x < s_q);
		stat.div_done = (dcnt_q == '0);
		stat.leap_done = (bit_q == {CntW{1'b1}});
	end
	assign result = r_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_SEED: begin
				sacc_q <= seed_val + GOLDEN;
				widx_q <= '0;
			end
			OP_MIXA, OP_MIXB: begin
				m0_q <= {32'd0, mx[31:0]} * {32'd0, mc[31:0]};
				m1_q <= mx[31:0] * mc[63:32];
				m2_q <= mx[63:32] * mc[31:0];
			end
			OP_MIXSUM: z_q <= m0_q + {m1_q + m2_q, 32'd0};
			OP_MIXC: begin
				w_q[widx_q] <= z_q ^ (z_q >> 31);
				widx_q <= widx_q + 2'd1;
				sacc_q <= sacc_q + GOLDEN;
			end
			OP_LOAD: begin
				s_q <= cmd.wide ? limit : {32'd0, limit[31:0]};
				thr_q <= '0;
				r_q <= '0;
			end
			OP_DRAW: begin
				out_raw <= rotl(w1x5, 7);
				w_q <= nw;
			end
			OP_MUL: begin
				p_q[0] <= {32'd0, rnd[31:0]} * {32'd0, s_q[31:0]};
				if (cmd.wide) begin
					p_q[1] <= {32'd0, rnd[31:0]} * {32'd0, s_q[63:32]};
					p_q[2] <= {32'd0, rnd[63:32]} * {32'd0, s_q[31:0]};
					p_q[3] <= {32'd0, rnd[63:32]} * {32'd0, s_q[63:32]};
				end else begin
					p_q[1] <= '0;
					p_q[2] <= '0;
					p_q[3] <= '0;
				end
			end
			OP_ADD: begin
				lo_q <= prod[63:0];
				r_q <= (action == ACT_NEXT) ? rnd :
					(cmd.wide ? prod[127:64] : {32'd0, prod[63:32]});
			end
			OP_DIVINIT: begin
				num_q <= cmd.wide ? (64'd0 - s_q) : {32'd0, 32'd0 - s_q[31:0]};
				rem_q <= '0;
				dcnt_q <= 7'd64;
			end
			OP_DIVSTEP: begin
				num_q <= num_q << 1;
				rem_q <= rem_sub[WordW] ? rem_sh[WordW-1:0] : rem_sub[WordW-1:0];
				dcnt_q <= dcnt_q - 7'd1;
				if (dcnt_q == 7'd1)
					thr_q <= rem_sub[WordW] ? rem_sh[WordW-1:0] : rem_sub[WordW-1:0];
			end
			OP_LEAPCLR: begin
				for (int k = 0; k < 4; k++)
					acc_q[k] <= '0;
				bit_q <= '0;
				r_q <= '0;
			end
			OP_LEAP: begin
				if (poly[bit_q])
					for (int k = 0; k < 4; k++)
						acc_q[k] <= acc_q[k] ^ w_q[k];
				w_q <= nw;
				bit_q <= bit_q + 1'b1;
			end
			OP_LEAPEND: begin
				for (int k = 0; k < 4; k++)
					w_q[k] <= poly[bit_q] ? (acc_q[k] ^ w_q[k]) : acc_q[k];
			end
			OP_ZERO: r_q <= '0;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ hw/rtl/xs_control.sv @@
// Controller: sequences seeding, draws, rejection and leaps
`timescale 1ns / 1ps
`default_nettype none
module xs_control (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic                     in_fire,
	input  wire logic [xs_pkg::ActW-1:0]  action,
	input  wire logic                     out_fire,
	input  wire xs_pkg::stat_t            stat,
	output xs_pkg::cmd_t                  cmd,
	output logic                          busy,
	output logic                          out_valid
);
	import xs_pkg::*;

	typedef enum logic [13:0] {
		S_SEED  = 14'b00000000000001,
		S_MIXA  = 14'b00000000000010,
		S_SUMA  = 14'b00000000000100,
		S_MIXB  = 14'b00000000001000,
		S_SUMB  = 14'b00000000010000,
		S_MIXC  = 14'b00000000100000,
		S_IDLE  = 14'b00000001000000,
		S_DRAW  = 14'b00000010000000,
		S_MUL   = 14'b00000100000000,
		S_ADD   = 14'b00001000000000,
		S_CHK   = 14'b00010000000000,
		S_DIV   = 14'b00100000000000,
		S_LEAP  = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic [1:0] wcnt_q;
	logic [ActW-1:0] act_q;
	logic thr_ok_q;
	logic wide;

	assign wide = (act_q == ACT_B64);
	assign busy = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd.wide = wide;
		cmd.op = OP_NONE;
		unique case (state_q)
			S_SEED: cmd.op = OP_SEED;
			S_MIXA: cmd.op = OP_MIXA;
			S_SUMA: cmd.op = OP_MIXSUM;
			S_MIXB: cmd.op = OP_MIXB;
			S_SUMB: cmd.op = OP_MIXSUM;
			S_MIXC: cmd.op = OP_MIXC;
			S_IDLE: begin
				cmd.wide = (action == ACT_B64);
				if (in_fire)
					cmd.op = (action == ACT_JUMP || action == ACT_LJUMP) ? OP_LEAPCLR :
						(action <= ACT_B64) ? OP_LOAD : OP_ZERO;
			end
			S_DRAW: cmd.op = OP_DRAW;
			S_MUL:  cmd.op = OP_MUL;
			S_ADD:  cmd.op = OP_ADD;
			S_CHK:  cmd.op = (stat.need_thr && !thr_ok_q) ? OP_DIVINIT : OP_NONE;
			S_DIV:  cmd.op = OP_DIVSTEP;
			S_LEAP: cmd.op = stat.leap_done ? OP_LEAPEND : OP_LEAP;
			S_OUT:  cmd.op = OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
		if (cfg_we)
			cmd.op = OP_SEED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SEED;
			wcnt_q <= '0;
			act_q <= ACT_NEXT;
			thr_ok_q <= 1'b0;
		end else if (cfg_we) begin
			state_q <= S_MIXA;
			wcnt_q <= '0;
		end else begin
			unique case (state_q)
				S_SEED: state_q <= S_MIXA;
				S_MIXA: state_q <= S_SUMA;
				S_SUMA: state_q <= S_MIXB;
				S_MIXB: state_q <= S_SUMB;
				S_SUMB: state_q <= S_MIXC;
				S_MIXC: begin
					wcnt_q <= wcnt_q + 2'd1;
					state_q <= (wcnt_q == 2'd3) ? S_IDLE : S_MIXA;
				end
				S_IDLE: if (in_fire) begin
					act_q <= action;
					thr_ok_q <= 1'b0;
					state_q <= (action == ACT_JUMP || action == ACT_LJUMP) ? S_LEAP :
						(action <= ACT_B64) ? S_DRAW : S_OUT;
				end
				S_DRAW: state_q <= S_MUL;
				S_MUL:  state_q <= S_ADD;
				S_ADD:  state_q <= (act_q == ACT_NEXT) ? S_OUT : S_CHK;
				S_CHK: begin
					if (!stat.need_thr)
						state_q <= S_OUT;
					else if (!thr_ok_q)
						state_q <= S_DIV;
					else
						state_q <= stat.reject ? S_DRAW : S_OUT;
				end
				S_DIV: if (stat.div_done) begin
					thr_ok_q <= 1'b1;
					state_q <= S_CHK;
				end
				S_LEAP: if (stat.leap_done) state_q <= S_OUT;
				S_OUT: if (out_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/xoshiro256ss_generator.sv @@
// Top level of the xoshiro256** random generator
// Usage:
//  Input channel in_valid/in_ready carries action and limit; output channel
//  out_valid/out_ready carries value. One item is worked on at a time.
//  Raw draw: DRAW, MUL and ADD states, then out_valid. Bounded draw: DRAW, MUL,
//  ADD and CHK, then out_valid when the draw is kept; each rejected draw goes
//  back to DRAW, and the rejection threshold divider runs once per item when it
//  is needed (limit above the low product half).
//  Jump and long jump: one generator step per cycle over the 256 polynomial
//  bits, the last bit folded in without a step. Unused actions return zero.
//  Reset and every seed write expand the seed by splitmix64 from 32-bit partial
//  products, one word at a time through the states MIXA, SUMA, MIXB, SUMB and
//  MIXC, with in_ready low. When the receiver stalls, value holds in its output
//  register and no new item is taken until it is accepted.
//  Seed writes are to be made only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module xoshiro256ss_generator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [xs_pkg::WordW-1:0]  cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [xs_pkg::ActW-1:0]   action,
	input  wire logic [xs_pkg::WordW-1:0]  limit,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [xs_pkg::WordW-1:0]       value
);
	import xs_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic busy;
	logic in_fire;
	logic [ActW-1:0] act_q;
	logic [WordW-1:0] lim_q;
	logic [ActW-1:0] act_sel;
	logic [WordW-1:0] lim_sel;

	assign in_ready = !busy && !cfg_we;
	assign in_fire = in_valid && in_ready;
	assign act_sel = in_fire ? action : act_q;
	assign lim_sel = in_fire ? limit : lim_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q <= action;
			lim_q <= limit;
		end
	end

	xs_control u_ctl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .in_fire(in_fire),
		.action(action), .out_fire(out_valid && out_ready), .stat(stat),
		.cmd(cmd), .busy(busy), .out_valid(out_valid)
	);

	xs_datapath u_dp (
		.clk(clk), .cmd(cmd), .seed_val(cfg_we ? cfg_wdata : '0),
		.action(act_sel), .limit(lim_sel), .stat(stat), .result(value)
	);
endmodule
`default_nettype wire

@@ hw/rtl/xs_checker.sv @@
// Port-level checker for the xoshiro256** generator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "xoshiro256ss_generator_assert.svh"
module xs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic cfg_we,
	input wire logic [63:0] value
);
	`XS_ASSERT_IMPL(a_no_in_when_out, clk, arst_n, out_valid, !in_ready)
	`XS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(value))
	`XS_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	`XS_ASSERT_NEXT(a_cfg_busy, clk, arst_n, cfg_we, !in_ready && !out_valid)
endmodule

bind xoshiro256ss_generator xs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .cfg_we(cfg_we), .value(value)
);
`default_nettype wire
